// ===== hdl/rpv_pkg.sv =====
package rpv_pkg;

  // Payload layout
  localparam int unsigned HEADER_LEN = 5;
  localparam int unsigned SLOT_LEN_SH = 2;  // four bytes per slot

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ERR_W   = 3;
  localparam int unsigned VLEN_W  = 11;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned EPOCH_W = 32;
  localparam int unsigned LEFT_W  = 10;
  localparam int unsigned PHASE_W = 3;

  localparam int unsigned RES_W = 1 + ERR_W + VLEN_W + CNT_W + EPOCH_W;
  localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_OK          = 3'd0;
  localparam logic [ERR_W-1:0] ERR_SHORT_HDR   = 3'd1;
  localparam logic [ERR_W-1:0] ERR_NAME_START  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_NAME_OVERRUN = 3'd3;
  localparam logic [ERR_W-1:0] ERR_SLOT_START  = 3'd4;
  localparam logic [ERR_W-1:0] ERR_SLOT_OVERRUN = 3'd5;
  localparam logic [ERR_W-1:0] ERR_TOO_LONG    = 3'd6;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch_seconds;
    logic [CNT_W-1:0]   record_count;
    logic [VLEN_W-1:0]  valid_length;
    logic [ERR_W-1:0]   error_code;
    logic               valid_res;
  } result_t;

endpackage

// ===== hdl/record_payload_validator.sv =====
// Record payload validator.
// Payload bytes arrive on the in_ stream, one byte per beat, in_tlast on the
// final byte. The header is a 4-byte big-endian epoch and a record count
// byte; each record is a length-prefixed name, a slot count and 4 bytes per
// slot. Bytes after the final record are accepted and counted.
// For each payload exactly one beat leaves on the out_ stream, carrying the
// valid flag, error code, accepted length (0 when invalid), record count and
// epoch. Bytes beyond MAX_LEN are counted as too long and not decoded.
// The last byte passes through the input register, then its verdict is loaded
// into the result register, which drives out_tvalid.
// Throughput: one byte per cycle, except while a last byte waits in the input
// register for the result register; the decoder is a small state machine with
// counters, updated once per registered byte.
// Reset (rst_n low, synchronous) empties both registers and returns the
// decoder to the header phase. After each last byte the decoder also returns
// to the header phase, ready for the next payload.
// When the receiver stalls, the result is held; the next payload's bytes keep
// flowing until a second last byte reaches the input register, which then
// waits and backs up in_tready.
module record_payload_validator
  import rpv_pkg::*;
#(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] data_byte
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [0] valid_res, [3:1] error_code,
                                             // [14:4] valid_length,
                                             // [22:15] record_count,
                                             // [54:23] epoch_seconds, zero pad
);

  localparam int unsigned POS_W = $clog2(MAX_LEN + 2);

  // Decoder phases
  localparam logic [PHASE_W-1:0] PH_HEADER    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_NAME_LEN  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_NAME_BODY = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SLOT_CNT  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SLOT_BODY = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DONE      = 3'd5;

  // Input register
  logic              s_vld_r;
  logic [BYTE_W-1:0] s_byte_r;
  logic              s_last_r;
  logic              adv;

  // Decoder state
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   recs_r, recs_nxt;
  logic [LEFT_W-1:0]  left_r, left_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // Result register
  logic    out_vld_r;
  result_t res_r, res_nxt;

  logic [LEFT_W-1:0] left_dec;
  logic [CNT_W-1:0]  recs_dec;
  logic [ERR_W-1:0]  err;

  // Handshake: the input stage moves on unless it holds a last byte and the
  // result register is still occupied and not being read
  assign adv       = !s_last_r || !out_vld_r || out_tready;
  assign in_tready = !s_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (in_tready) begin
      s_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s_byte_r <= in_tdata;
      s_last_r <= in_tlast;
    end
  end

  // Byte decoder
  assign left_dec = left_r - LEFT_W'(1);
  assign recs_dec = recs_r - CNT_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    recs_nxt  = recs_r;
    left_nxt  = left_r;
    epoch_nxt = epoch_r;
    cnt_nxt   = cnt_r;
    if (pos_r <= POS_W'(MAX_LEN)) begin
      pos_nxt = pos_r + POS_W'(1);
      unique case (phase_r)
        PH_HEADER: begin
          if (pos_nxt < POS_W'(HEADER_LEN)) begin
            epoch_nxt = {epoch_r[EPOCH_W-BYTE_W-1:0], s_byte_r};
          end else begin
            cnt_nxt   = s_byte_r;
            recs_nxt  = s_byte_r;
            phase_nxt = (s_byte_r == '0) ? PH_DONE : PH_NAME_LEN;
          end
        end
        PH_NAME_LEN: begin
          if (s_byte_r == '0) begin
            phase_nxt = PH_SLOT_CNT;
          end else begin
            left_nxt  = LEFT_W'(s_byte_r);
            phase_nxt = PH_NAME_BODY;
          end
        end
        PH_NAME_BODY: begin
          left_nxt = left_dec;
          if (left_dec == '0) phase_nxt = PH_SLOT_CNT;
        end
        PH_SLOT_CNT: begin
          if (s_byte_r == '0) begin
            recs_nxt  = recs_dec;
            phase_nxt = (recs_dec == '0) ? PH_DONE : PH_NAME_LEN;
          end else begin
            left_nxt  = {s_byte_r, {SLOT_LEN_SH{1'b0}}};
            phase_nxt = PH_SLOT_BODY;
          end
        end
        PH_SLOT_BODY: begin
          left_nxt = left_dec;
          if (left_dec == '0) begin
            recs_nxt  = recs_dec;
            phase_nxt = (recs_dec == '0) ? PH_DONE : PH_NAME_LEN;
          end
        end
        default: ;
      endcase
    end
  end

  // Verdict on the last byte
  always_comb begin
    if (pos_nxt > POS_W'(MAX_LEN)) begin
      err = ERR_TOO_LONG;
    end else begin
      unique case (phase_nxt)
        PH_HEADER:    err = ERR_SHORT_HDR;
        PH_NAME_LEN:  err = ERR_NAME_START;
        PH_NAME_BODY: err = ERR_NAME_OVERRUN;
        PH_SLOT_CNT:  err = ERR_SLOT_START;
        PH_SLOT_BODY: err = ERR_SLOT_OVERRUN;
        default:      err = ERR_OK;
      endcase
    end
    res_nxt.valid_res     = (err == ERR_OK);
    res_nxt.error_code    = err;
    res_nxt.valid_length  = (err == ERR_OK) ? VLEN_W'(pos_nxt) : '0;
    res_nxt.record_count  = (err == ERR_SHORT_HDR) ? '0 : cnt_nxt;
    res_nxt.epoch_seconds = (err == ERR_SHORT_HDR) ? '0 : epoch_nxt;
  end

  // State update; a last byte returns the decoder to the header phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      recs_r  <= '0;
      left_r  <= '0;
      epoch_r <= '0;
      cnt_r   <= '0;
    end else if (s_vld_r && adv) begin
      if (s_last_r) begin
        phase_r <= PH_HEADER;
        pos_r   <= '0;
        recs_r  <= '0;
        left_r  <= '0;
        epoch_r <= '0;
        cnt_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        recs_r  <= recs_nxt;
        left_r  <= left_nxt;
        epoch_r <= epoch_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s_vld_r && s_last_r && adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_vld_r && s_last_r && adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'(res_r);

endmodule
